### hdl/ume_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ume_pkg
// Shared types and constants of the register execute unit.
// ---------------------------------------------------------------------------
package ume_pkg;

    localparam int DATA_W             = 32;
    localparam int CMD_W              = 4;
    localparam int REG_FIELD_W        = 3;
    localparam int BYTE_W             = 8;
    localparam int REGISTER_COUNT_DEF = 8;
    localparam int S_TDATA_W          = 56;
    localparam int M_TDATA_W          = 80;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] BYTE_MAX = 32'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_CMOV       = 4'd0,
        CMD_ADD        = 4'd1,
        CMD_MUL        = 4'd2,
        CMD_DIV        = 4'd3,
        CMD_NAND       = 4'd4,
        CMD_OUTPUT     = 4'd5,
        CMD_INPUT      = 4'd6,
        CMD_LOAD_PROG  = 4'd7,
        CMD_LOAD_VALUE = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_DIV_ZERO = 2'd1,
        FAULT_RANGE    = 2'd2
    } fault_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic start_div;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_div;
        logic div_zero;
        logic div_done;
    } dp_status_t;

endpackage

### hdl/ume_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ume_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ume_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ume_pkg::DATA_W-1:0]  dividend,
    input  logic [ume_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [ume_pkg::DATA_W-1:0]  quotient
);
    import ume_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/ume_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ume_dpath
// Register file, program counter, operand and result registers, multiplier
// and divider of the execute unit.
// ---------------------------------------------------------------------------
module ume_dpath #(
    parameter int REGISTER_COUNT = ume_pkg::REGISTER_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ume_pkg::S_TDATA_W-1:0] s_tdata,
    input  ume_pkg::ctrl_cmd_t            ctrl,
    output ume_pkg::dp_status_t           status,
    output logic [ume_pkg::M_TDATA_W-1:0] m_tdata
);
    import ume_pkg::*;

    localparam int ADDR_W = (REGISTER_COUNT > 2) ? $clog2(REGISTER_COUNT) : 1;
    localparam logic [4:0] COUNT_V = 5'(REGISTER_COUNT);

    // request fields
    cmd_t                   s_cmd;
    logic [REG_FIELD_W-1:0] s_ra, s_rb, s_rc;
    logic [DATA_W-1:0]      s_imm;
    logic [BYTE_W-1:0]      s_byte;
    logic                   s_end;

    assign s_cmd  = cmd_t'(s_tdata[3:0]);
    assign s_ra   = s_tdata[6:4];
    assign s_rb   = s_tdata[9:7];
    assign s_rc   = s_tdata[12:10];
    assign s_imm  = s_tdata[44:13];
    assign s_byte = s_tdata[52:45];
    assign s_end  = s_tdata[53];

    // register file
    logic [DATA_W-1:0]         regs_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] valid_reg;

    logic [ADDR_W-1:0] addr_b, addr_c;
    logic              range_b, range_c;

    assign addr_b  = ADDR_W'(s_rb);
    assign addr_c  = ADDR_W'(s_rc);
    assign range_b = ({2'b00, s_rb} < COUNT_V);
    assign range_c = ({2'b00, s_rc} < COUNT_V);

    cmd_t                   cmd_reg;
    logic [REG_FIELD_W-1:0] ra_reg, rc_reg;
    logic [DATA_W-1:0]      imm_reg;
    logic [BYTE_W-1:0]      byte_reg;
    logic                   end_reg;
    logic [DATA_W-1:0]      rd_b_reg, rd_c_reg;
    logic                   hit_b_reg, hit_c_reg;
    logic [DATA_W-1:0]      product_reg;
    logic [DATA_W-1:0]      pc_reg;

    logic [DATA_W-1:0]      vb, vc;
    logic [2*DATA_W-1:0]    prod_full;
    logic [DATA_W-1:0]      quotient;
    logic                   div_done;

    // write side
    logic                   wr_req;
    logic [REG_FIELD_W-1:0] wr_idx;
    logic [DATA_W-1:0]      wr_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [DATA_W-1:0]      pc_next;
    fault_t                 fault_c;
    logic                   char_c;
    logic                   creq_c;

    // result registers
    logic                   res_char_reg;
    logic [BYTE_W-1:0]      res_byte_reg;
    logic [DATA_W-1:0]      res_pc_reg;
    logic                   res_creq_reg;
    logic [DATA_W-1:0]      res_cseg_reg;
    fault_t                 res_fault_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg   <= s_cmd;
            ra_reg    <= s_ra;
            rc_reg    <= s_rc;
            imm_reg   <= s_imm;
            byte_reg  <= s_byte;
            end_reg   <= s_end;
            rd_b_reg  <= regs_mem[addr_b];
            rd_c_reg  <= regs_mem[addr_c];
            hit_b_reg <= range_b && valid_reg[addr_b];
            hit_c_reg <= range_c && valid_reg[addr_c];
        end
        if (wr_en) begin
            regs_mem[wr_addr] <= wr_data;
        end
        product_reg <= prod_full[DATA_W-1:0];
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign vb        = hit_b_reg ? rd_b_reg : '0;
    assign vc        = hit_c_reg ? rd_c_reg : '0;
    assign prod_full = vb * vc;

    ume_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.start_div),
        .dividend (vb),
        .divisor  (vc),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        wr_req  = 1'b0;
        wr_idx  = ra_reg;
        wr_data = vb;
        pc_next = pc_reg + 1'b1;
        fault_c = FAULT_NONE;
        char_c  = 1'b0;
        creq_c  = 1'b0;
        case (cmd_reg)
            CMD_CMOV: begin
                wr_req = (vc != '0);
            end
            CMD_ADD: begin
                wr_req  = 1'b1;
                wr_data = vb + vc;
            end
            CMD_MUL: begin
                wr_req  = 1'b1;
                wr_data = product_reg;
            end
            CMD_DIV: begin
                if (vc == '0) begin
                    fault_c = FAULT_DIV_ZERO;
                    pc_next = pc_reg;
                end else begin
                    wr_req  = 1'b1;
                    wr_data = quotient;
                end
            end
            CMD_NAND: begin
                wr_req  = 1'b1;
                wr_data = ~(vb & vc);
            end
            CMD_OUTPUT: begin
                if (vc > BYTE_MAX) begin
                    fault_c = FAULT_RANGE;
                    pc_next = pc_reg;
                end else begin
                    char_c = 1'b1;
                end
            end
            CMD_INPUT: begin
                wr_req  = 1'b1;
                wr_idx  = rc_reg;
                wr_data = end_reg ? ALL_ONES : {{(DATA_W-BYTE_W){1'b0}}, byte_reg};
            end
            CMD_LOAD_PROG: begin
                creq_c  = (vb != '0);
                pc_next = vc;
            end
            CMD_LOAD_VALUE: begin
                wr_req  = 1'b1;
                wr_data = imm_reg;
            end
            default: begin
                wr_req = 1'b0;
            end
        endcase
    end

    assign wr_addr = ADDR_W'(wr_idx);
    assign wr_en   = ctrl.commit && wr_req && ({2'b00, wr_idx} < COUNT_V);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            res_char_reg  <= 1'b0;
            res_byte_reg  <= '0;
            res_pc_reg    <= '0;
            res_creq_reg  <= 1'b0;
            res_cseg_reg  <= '0;
            res_fault_reg <= FAULT_NONE;
        end else if (ctrl.commit) begin
            pc_reg        <= pc_next;
            res_char_reg  <= char_c;
            res_byte_reg  <= char_c ? vc[BYTE_W-1:0] : '0;
            res_pc_reg    <= pc_next;
            res_creq_reg  <= creq_c;
            res_cseg_reg  <= creq_c ? vb : '0;
            res_fault_reg <= fault_c;
        end
    end

    assign status.is_div   = (cmd_reg == CMD_DIV);
    assign status.div_zero = (vc == '0);
    assign status.div_done = div_done;

    assign m_tdata = {4'b0000, res_fault_reg, res_cseg_reg, res_creq_reg,
                      res_pc_reg, res_byte_reg, res_char_reg};

    a_fault_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.commit && fault_c != FAULT_NONE) |-> !wr_en)
        else $error("register written on a faulting instruction");

    a_fault_pc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.commit && fault_c != FAULT_NONE) |=> (pc_reg == $past(pc_reg)))
        else $error("program counter moved on a fault");

    a_copy_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        res_creq_reg |-> (res_cseg_reg != '0))
        else $error("copy request with segment zero");

    a_char_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        res_char_reg |-> (res_fault_reg == FAULT_NONE))
        else $error("character emitted together with a fault");

endmodule

### hdl/ume_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ume_ctrl
// Sequencer of the execute unit: accept, execute, divide wait, write back.
// ---------------------------------------------------------------------------
module ume_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ume_pkg::dp_status_t  status,
    output ume_pkg::ctrl_cmd_t   ctrl
);
    import ume_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ctrl.load      = 1'b0;
        ctrl.start_div = 1'b0;
        ctrl.commit    = 1'b0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.is_div && !status.div_zero) begin
                    ctrl.start_div = 1'b1;
                    state_next     = ST_DIV;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (ctrl.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

### hdl/um_register_execute_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// um_register_execute_unit
// Executes one decoded instruction per request on a register file and a
// program counter; one result per request.
// ---------------------------------------------------------------------------
// sequence: accept in idle, execute, divide wait for a divide by a nonzero
//   register (32-step shift-subtract divider), write back once the output
//   register is free; a new request is accepted only after write back
// reset: synchronous, clears counter and register valid bits; registers read
//   as zero until written, no clearing pass
// ---------------------------------------------------------------------------
module um_register_execute_unit #(
    parameter int REGISTER_COUNT = ume_pkg::REGISTER_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command, reg_a, reg_b, reg_c, immediate, in_byte, in_end
    input  logic [ume_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_valid, out_byte, next_pc, copy_request, copy_segment, fault
    output logic [ume_pkg::M_TDATA_W-1:0] m_tdata
);
    import ume_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    ume_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    ume_dpath #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .ctrl    (ctrl),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for um_register_execute_unit: directed requests on the
// reset state, every command, the fault cases and the unused codes, then a
// long random run, all checked against a local model of registers and pc.
// ---------------------------------------------------------------------------
module tb;
    import ume_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 60;
    localparam int REG_COUNT    = REGISTER_COUNT_DEF;

    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

    localparam logic [2:0] R0 = 3'd0, R1 = 3'd1, R2 = 3'd2, R3 = 3'd3;
    localparam logic [2:0] R4 = 3'd4, R5 = 3'd5, R6 = 3'd6, R7 = 3'd7;

    // request fields, lowest bit first: command, reg_a, reg_b, reg_c,
    // immediate, in_byte, in_end
    typedef struct packed {
        logic              in_end;
        logic [BYTE_W-1:0] in_byte;
        logic [DATA_W-1:0] immediate;
        logic [2:0]        reg_c;
        logic [2:0]        reg_b;
        logic [2:0]        reg_a;
        logic [CMD_W-1:0]  command;
    } request_t;

    // result fields, lowest bit first: out_valid, out_byte, next_pc,
    // copy_request, copy_segment, fault
    typedef struct packed {
        logic [1:0]        fault;
        logic [DATA_W-1:0] copy_segment;
        logic              copy_request;
        logic [DATA_W-1:0] next_pc;
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
    } result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [DATA_W-1:0] arch_regs [REG_COUNT];
    logic [DATA_W-1:0] arch_pc;
    result_t           pending_results [$];
    int                error_count;
    int                cycle_count;
    bit                idling_on;
    int                ready_hold;

    um_register_execute_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL um_register_execute_unit");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int pick;
        if (!idling_on) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] read_reg(logic [2:0] idx);
        if (idx < REG_COUNT) return arch_regs[idx];
        return '0;
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
        if (idx < REG_COUNT) arch_regs[idx] = value;
    endfunction

    // executes one instruction on the local machine state
    function automatic result_t exec_instruction(request_t req);
        result_t           res;
        logic [DATA_W-1:0] vb;
        logic [DATA_W-1:0] vc;
        logic [63:0]       product;
        logic [DATA_W-1:0] pc_after;
        vb       = read_reg(req.reg_b);
        vc       = read_reg(req.reg_c);
        pc_after = arch_pc + 1;
        res      = '0;
        case (req.command)
            CMD_CMOV: begin
                if (vc != 0) write_reg(req.reg_a, vb);
            end
            CMD_ADD: write_reg(req.reg_a, vb + vc);
            CMD_MUL: begin
                product = 64'(vb) * 64'(vc);
                write_reg(req.reg_a, product[DATA_W-1:0]);
            end
            CMD_DIV: begin
                if (vc == 0) begin
                    res.fault = FAULT_DIV_ZERO;
                    pc_after  = arch_pc;
                end else begin
                    write_reg(req.reg_a, vb / vc);
                end
            end
            CMD_NAND: write_reg(req.reg_a, ~(vb & vc));
            CMD_OUTPUT: begin
                if (vc > BYTE_MAX) begin
                    res.fault = FAULT_RANGE;
                    pc_after  = arch_pc;
                end else begin
                    res.out_valid = 1'b1;
                    res.out_byte  = vc[BYTE_W-1:0];
                end
            end
            CMD_INPUT: write_reg(req.reg_c, req.in_end ? ALL_ONES : DATA_W'(req.in_byte));
            CMD_LOAD_PROG: begin
                if (vb != 0) begin
                    res.copy_request = 1'b1;
                    res.copy_segment = vb;
                end
                pc_after = vc;
            end
            CMD_LOAD_VALUE: write_reg(req.reg_a, req.immediate);
            default: ;
        endcase
        arch_pc     = pc_after;
        res.next_pc = pc_after;
        return res;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] command, input logic [2:0] ra,
                                input logic [2:0] rb, input logic [2:0] rc,
                                input logic [DATA_W-1:0] immediate = $urandom,
                                input logic [BYTE_W-1:0] in_byte = 8'($urandom),
                                input logic in_end = 1'b0);
        request_t req;
        int       gap;
        req.command   = command;
        req.reg_a     = ra;
        req.reg_b     = rb;
        req.reg_c     = rc;
        req.immediate = immediate;
        req.in_byte   = in_byte;
        req.in_end    = in_end;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= S_TDATA_W'(req);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(exec_instruction(req));
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] expected,
                               input logic [DATA_W-1:0] actual);
        if (expected !== actual) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $realtime, name, expected, actual);
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $realtime, got);
            end else begin
                want = pending_results.pop_front();
                check_field("out_valid", DATA_W'(want.out_valid), DATA_W'(got.out_valid));
                check_field("out_byte", DATA_W'(want.out_byte), DATA_W'(got.out_byte));
                check_field("next_pc", want.next_pc, got.next_pc);
                check_field("copy_request", DATA_W'(want.copy_request),
                            DATA_W'(got.copy_request));
                check_field("copy_segment", want.copy_segment, got.copy_segment);
                check_field("fault", DATA_W'(want.fault), DATA_W'(got.fault));
            end
        end
    end

    // result side back-pressure
    initial begin
        m_tready   = 1'b0;
        ready_hold = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_tready   <= 1'b1;
                ready_hold = idle_gap();
            end
        end
    end

    // registers are all zero after reset
    task automatic test_reset_state();
        send_request(CMD_DIV, R1, R2, R3);
        send_request(CMD_OUTPUT, R0, R0, R4);
        send_request(CMD_CMOV, R1, R2, R3);
    endtask

    task automatic test_arithmetic();
        send_request(CMD_LOAD_VALUE, R1, R0, R0, ALL_ONES);
        send_request(CMD_LOAD_VALUE, R2, R0, R0, 32'd2);
        send_request(CMD_ADD, R3, R1, R2);
        send_request(CMD_MUL, R4, R1, R1);
        send_request(CMD_DIV, R5, R1, R2);
        send_request(CMD_NAND, R6, R1, R2);
        send_request(CMD_CMOV, R5, R1, R2);
    endtask

    task automatic test_char_io();
        send_request(CMD_LOAD_VALUE, R7, R0, R0, BYTE_MAX);
        send_request(CMD_OUTPUT, R0, R0, R7);
        send_request(CMD_LOAD_VALUE, R6, R0, R0, BYTE_MAX + 1);
        send_request(CMD_OUTPUT, R0, R0, R6);
        send_request(CMD_INPUT, R3, R4, R0, '0, 8'hA5, 1'b0);
        send_request(CMD_INPUT, R3, R4, R0, '0, 8'h5A, 1'b1);
    endtask

    task automatic test_load_program();
        send_request(CMD_LOAD_VALUE, R6, R0, R0, '0);
        send_request(CMD_CMOV, R5, R1, R6);
        send_request(CMD_LOAD_PROG, R0, R6, R2);
        send_request(CMD_LOAD_PROG, R0, R1, R1);
        // counter wraps from all ones to zero
        send_request(CMD_ADD, R3, R2, R2);
    endtask

    task automatic test_unused_codes();
        for (int code = CMD_UNUSED_FIRST; code <= CMD_UNUSED_LAST; code++)
            send_request(CMD_W'(code), 3'($urandom), 3'($urandom), 3'($urandom));
    endtask

    task automatic test_random_programs();
        int                pick;
        logic [DATA_W-1:0] immediate;
        logic [CMD_W-1:0]  command;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // first stretch runs back to back
            idling_on = (n >= 200);
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 4))
                0:       immediate = $urandom_range(0, 300);
                1:       immediate = '0;
                2:       immediate = ALL_ONES;
                default: immediate = $urandom;
            endcase
            if (pick < 22)      command = CMD_LOAD_VALUE;
            else if (pick < 32) command = CMD_ADD;
            else if (pick < 40) command = CMD_MUL;
            else if (pick < 52) command = CMD_DIV;
            else if (pick < 59) command = CMD_NAND;
            else if (pick < 70) command = CMD_OUTPUT;
            else if (pick < 79) command = CMD_INPUT;
            else if (pick < 86) command = CMD_LOAD_PROG;
            else if (pick < 95) command = CMD_CMOV;
            else command = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            send_request(command, 3'($urandom), 3'($urandom), 3'($urandom), immediate,
                         8'($urandom), ($urandom_range(0, 5) == 0));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        error_count = 0;
        cycle_count = 0;
        idling_on   = 1'b1;
        arch_pc     = '0;
        for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_arithmetic();
        test_char_io();
        test_load_program();
        test_unused_codes();
        test_random_programs();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("PASS um_register_execute_unit");
        else
            $display("FAIL um_register_execute_unit");
        $finish;
    end

endmodule

### sim.f
hdl/ume_pkg.sv
hdl/ume_div.sv
hdl/ume_dpath.sv
hdl/ume_ctrl.sv
hdl/um_register_execute_unit.sv
sim/tb.sv
